### design/pctq_pkg.sv
`timescale 1ns / 1ps

package pctq_pkg;

    // Default sizing
    localparam int NUM_CORES_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int TASK_BITS_DEF   = 16;

    // Fixed field widths
    localparam int CORE_FW  = 8;
    localparam int IDENT_FW = 16;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic {
        OP_SCHED = 1'b0,
        OP_POLL  = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_META  = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

endpackage

### design/per_core_task_queues_top.sv
// A schedule, an invalid core or an empty poll returns a single result beat; a drain
// returns one beat per task, one beat a cycle while the output is not stalled.
// The block takes one item at a time: its input stalls until the item's last result
// beat is loaded into the output register.
// Reset (i_rst_n low, synchronous): FSM idle, output empty, every core's head/count
// reads as zero at once through per-core valid bits; task memory is not cleared.
`timescale 1ns / 1ps

module per_core_task_queues_top #(
    parameter int NUM_CORES   = pctq_pkg::NUM_CORES_DEF,
    parameter int QUEUE_DEPTH = pctq_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_BITS   = pctq_pkg::TASK_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_op,
    input  logic signed [pctq_pkg::CORE_FW-1:0] i_core,
    input  logic [pctq_pkg::IDENT_FW-1:0]       i_task_ident,
    // Result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output pctq_pkg::t_status                   o_status,
    output logic [pctq_pkg::IDENT_FW-1:0]       o_drained_task,
    output logic                                o_has_task,
    output logic                                o_last
);
    import pctq_pkg::*;

    // Stored identifier width: identifiers arrive 16 bits wide and are cut to TASK_BITS.
    localparam int TW     = (TASK_BITS < IDENT_FW) ? TASK_BITS : IDENT_FW;
    // Slot index within a queue, occupancy count (holds QUEUE_DEPTH), and their sum.
    localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int CORE_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int META_W = SLOT_W + CNT_W;
    localparam int TADR_W = CORE_W + SLOT_W;

    // ------------------------------------------------------------------
    // Storage
    //   mem_task : one region of 2**SLOT_W slots per core, addressed {core, slot}
    //   mem_meta : per-core {head, count}; a core whose valid bit is clear
    //              reads as head 0 / count 0 (reset value)
    // ------------------------------------------------------------------
    logic [TW-1:0]     mem_task [2**TADR_W];
    logic [META_W-1:0] mem_meta [2**CORE_W];
    logic [2**CORE_W-1:0] r_meta_vld;

    // Control and captured item
    t_state             r_state, n_state;
    t_op                r_op;
    logic [CORE_W-1:0]  r_core;
    logic               r_inval;
    logic [TW-1:0]      r_ident;

    // Memory read registers
    logic [META_W-1:0]  r_meta_rd;
    logic               r_meta_hit;
    logic [TW-1:0]      r_task_rd;

    // Drain walk
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [CNT_W-1:0]   r_left, n_left;

    // Output register
    logic               r_out_valid;
    t_status            r_status;
    logic [TW-1:0]      r_task;
    logic               r_has;
    logic               r_last;

    // Memory access strobes
    logic               meta_re;
    logic               meta_we;
    logic [META_W-1:0]  meta_wdata;
    logic               task_we;
    logic               task_re;
    logic [SLOT_W-1:0]  task_slot;

    // Output load
    logic               out_free;
    logic               out_load;
    t_status            out_status;
    logic [TW-1:0]      out_task;
    logic               out_has;
    logic               out_last;

    // Decoded metadata
    logic [SLOT_W-1:0]  meta_head;
    logic [CNT_W-1:0]   meta_cnt;
    logic [SUM_W-1:0]   head_sum;
    logic [SLOT_W-1:0]  tail_slot;
    logic [SLOT_W-1:0]  head_next;
    logic               in_inval;

    // Negative cores are >= 128 as unsigned, so one compare covers both cases.
    assign in_inval = ($unsigned(i_core) >= CORE_FW'(NUM_CORES));

    assign meta_head = r_meta_hit ? r_meta_rd[META_W-1:CNT_W] : '0;
    assign meta_cnt  = r_meta_hit ? r_meta_rd[CNT_W-1:0]      : '0;

    // (head + count) mod depth: head stays below depth and count at most depth
    // (count < depth on push, count <= depth on drain), so one compare and subtract suffices.
    // Tail slot for a push and new head after a drain are the same value.
    always_comb begin
        head_sum = SUM_W'(meta_head) + SUM_W'(meta_cnt);
        if (head_sum >= SUM_W'(QUEUE_DEPTH)) begin
            head_sum = head_sum - SUM_W'(QUEUE_DEPTH);
        end
        tail_slot = head_sum[SLOT_W-1:0];
    end

    assign head_next = (SUM_W'(meta_head) == SUM_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : meta_head + SLOT_W'(1);

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // ------------------------------------------------------------------
    // Sequencer
    //   IDLE : take a beat, read the core's head/count
    //   META : decide; push that fits writes task + count, non-empty poll starts the drain
    //   DRAIN: one task read and result load per cycle while output is free
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_left     = r_left;
        meta_re    = 1'b0;
        meta_we    = 1'b0;
        meta_wdata = '0;
        task_we    = 1'b0;
        task_re    = 1'b0;
        task_slot  = r_slot;
        out_load   = 1'b0;
        out_status = ST_OK;
        out_task   = '0;
        out_has    = 1'b0;
        out_last   = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    meta_re = 1'b1;
                    n_state = S_META;
                end
            end
            S_META: begin
                if (r_inval) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        out_status = ST_INVALID;
                        n_state    = S_IDLE;
                    end
                end else if (r_op == OP_SCHED) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        n_state  = S_IDLE;
                        if (meta_cnt >= CNT_W'(QUEUE_DEPTH)) begin
                            out_status = ST_FULL;
                        end else begin
                            out_status = ST_OK;
                            task_we    = 1'b1;
                            task_slot  = tail_slot;
                            meta_we    = 1'b1;
                            meta_wdata = {meta_head, meta_cnt + CNT_W'(1)};
                        end
                    end
                end else if (meta_cnt == '0) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        out_status = ST_EMPTY;
                        n_state    = S_IDLE;
                    end
                end else begin
                    // Queue empties in one go; the head moves past every drained task.
                    task_re    = 1'b1;
                    task_slot  = meta_head;
                    n_slot     = head_next;
                    n_left     = meta_cnt;
                    meta_we    = 1'b1;
                    meta_wdata = {tail_slot, CNT_W'(0)};
                    n_state    = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = ST_OK;
                    out_task   = r_task_rd;
                    out_has    = 1'b1;
                    out_last   = (r_left == CNT_W'(1));
                    n_left     = r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        task_re = 1'b1;
                        n_slot  = (SUM_W'(r_slot) == SUM_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : r_slot + SLOT_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_meta_vld  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= out_load || (r_out_valid && i_out_stall);
            if (meta_we) begin
                r_meta_vld[r_core] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_op    <= t_op'(i_op);
            r_core  <= i_core[CORE_W-1:0];
            r_inval <= in_inval;
            r_ident <= i_task_ident[TW-1:0];
        end
        r_slot <= n_slot;
        r_left <= n_left;
        if (out_load) begin
            r_status <= out_status;
            r_task   <= out_task;
            r_has    <= out_has;
            r_last   <= out_last;
        end
    end

    // Head/count memory: read in IDLE, written back in META
    always_ff @(posedge i_clk) begin
        if (meta_re) begin
            r_meta_rd  <= mem_meta[i_core[CORE_W-1:0]];
            r_meta_hit <= r_meta_vld[i_core[CORE_W-1:0]];
        end
        if (meta_we) begin
            mem_meta[r_core] <= meta_wdata;
        end
    end

    // Task memory: read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (task_re) begin
            r_task_rd <= mem_task[{r_core, task_slot}];
        end
        if (task_we) begin
            mem_task[{r_core, task_slot}] <= r_ident;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_drained_task = IDENT_FW'(r_task);
    assign o_has_task     = r_has;
    assign o_last         = r_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_task_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_has_task |-> o_status == ST_OK)
        else $error("drained task beat with non-ok status");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_task |-> o_last)
        else $error("status-only beat without last");

    a_take_meta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_state == S_META)
        else $error("accepted beat did not reach the metadata stage");

    a_drain_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DRAIN |-> r_left != '0)
        else $error("drain running with nothing left");

    a_no_wr_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DRAIN |-> !task_we && !meta_we)
        else $error("memory write during drain");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

// Bench for the per-core task queues. Every accepted input beat is run through a
// local copy of the queue state (store, head slot and count per core), which
// appends the beats the block owes to a FIFO. Every accepted output beat is
// checked against the oldest entry of that FIFO.
module tb;
    import pctq_pkg::*;

    localparam int NUM_CORES   = NUM_CORES_DEF;
    localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
    localparam int TASK_BITS   = TASK_BITS_DEF;
    localparam logic [IDENT_FW-1:0] IDENT_MASK = IDENT_FW'((64'h1 << TASK_BITS) - 1);

    localparam int RANDOM_ITEMS   = 270;
    localparam int MAX_SHOWN      = 10;
    // Longest correct stretch with no beat either way is a sender gap, the
    // drain start and a receiver stall.
    localparam int WATCHDOG_LIMIT = 400;
    localparam int TAIL_CYCLES    = 12;

    // One output beat as the block should present it.
    typedef struct packed {
        t_status             status;
        logic [IDENT_FW-1:0] drained;
        logic                has_task;
        logic                last;
    } t_result_beat;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_in_valid   = 1'b0;
    logic                       o_in_stall;
    logic                       i_op         = 1'b0;
    logic signed [CORE_FW-1:0]  i_core       = '0;
    logic [IDENT_FW-1:0]        i_task_ident = '0;
    logic                       o_out_valid;
    logic                       i_out_stall  = 1'b0;
    t_status                    o_status;
    logic [IDENT_FW-1:0]        o_drained_task;
    logic                       o_has_task;
    logic                       o_last;

    per_core_task_queues_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_core         (i_core),
        .i_task_ident   (i_task_ident),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_drained_task (o_drained_task),
        .o_has_task     (o_has_task),
        .o_last         (o_last)
    );

    always #6 i_clk = ~i_clk;

    // Shadow of the block's queue state.
    logic [IDENT_FW-1:0] task_mem [NUM_CORES][QUEUE_DEPTH];
    logic [4:0]          head_slot [NUM_CORES];
    logic [5:0]          queued    [NUM_CORES];

    t_result_beat owed_beats[$];   // results still to come, oldest first
    int           mismatches  = 0;
    int           items_sent  = 0;
    int           idle_cycles = 0;
    int           stall_left  = 0;
    bit           no_idle     = 1'b0;   // when set, neither side inserts gaps

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 8));
    endfunction

    function automatic void owe_beat(t_status st, logic [IDENT_FW-1:0] drained,
                                     logic has, logic last);
        t_result_beat b;
        b.status   = st;
        b.drained  = drained;
        b.has_task = has;
        b.last     = last;
        owed_beats.insert(owed_beats.size(), b);
    endfunction

    // Work out what one accepted input beat makes the block emit, and update
    // the shadow queues the same way the block should.
    function automatic void predict_queue_op(t_op op, logic [CORE_FW-1:0] core,
                                             logic [IDENT_FW-1:0] ident);
        int c;
        int n;
        int h;
        if (core[CORE_FW-1] || int'(core) >= NUM_CORES) begin
            // negative or out-of-range core, either op, no state change
            owe_beat(ST_INVALID, '0, 1'b0, 1'b1);
            return;
        end
        c = int'(core);
        n = int'(queued[c]);
        h = int'(head_slot[c]);
        if (op == OP_SCHED) begin
            if (n >= QUEUE_DEPTH) begin
                owe_beat(ST_FULL, '0, 1'b0, 1'b1);   // dropped
            end else begin
                task_mem[c][(h + n) % QUEUE_DEPTH] = ident & IDENT_MASK;
                queued[c] = 6'(n + 1);
                owe_beat(ST_OK, '0, 1'b0, 1'b1);
            end
        end else if (n == 0) begin
            owe_beat(ST_EMPTY, '0, 1'b0, 1'b1);
        end else begin
            // drain oldest first, last flag on the final task only
            for (int i = 0; i < n; i++)
                owe_beat(ST_OK, task_mem[c][(h + i) % QUEUE_DEPTH] & IDENT_MASK, 1'b1,
                         (i == n - 1));
            head_slot[c] = 5'((h + n) % QUEUE_DEPTH);
            queued[c]    = '0;
        end
    endfunction

    // Output side: check each accepted beat, then draw the stall for the next.
    always @(posedge i_clk) begin
        t_result_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_beats.size() == 0) begin
                if (mismatches < MAX_SHOWN)
                    $display("unexpected result beat: status=%0d task=%h has=%b last=%b",
                             o_status, o_drained_task, o_has_task, o_last);
                mismatches++;
            end else begin
                want = owed_beats.pop_front();
                if (o_status !== want.status || o_drained_task !== want.drained ||
                    o_has_task !== want.has_task || o_last !== want.last) begin
                    if (mismatches < MAX_SHOWN)
                        $display({"result mismatch: expected status=%0d task=%h has=%b ",
                                  "last=%b, got status=%0d task=%h has=%b last=%b"},
                                 want.status, want.drained, want.has_task, want.last,
                                 o_status, o_drained_task, o_has_task, o_last);
                    mismatches++;
                end
            end
            stall_left = draw_gap();
            i_out_stall <= (stall_left > 0);
        end else if (i_out_stall) begin
            // count the stall down and release it once the drawn gap has run out
            if (stall_left <= 1) begin
                stall_left = 0;
                i_out_stall <= 1'b0;
            end else begin
                stall_left = stall_left - 1;
            end
        end
    end

    // Watchdog: too long with no beat accepted on either side ends the run.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("per_core_task_queues_top verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one input beat after a random gap and hold it until accepted.
    // Called at a rising edge; valid stays high straight into the next beat
    // when the gap is zero.
    task automatic send_item(input t_op op, input logic [CORE_FW-1:0] core,
                             input logic [IDENT_FW-1:0] ident);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_core       <= core;
        i_task_ident <= ident;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_queue_op(op, core, ident);
        items_sent++;
    endtask

    // Sender backs off until every owed result has come out.
    task automatic wait_queues_quiet();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (owed_beats.size() != 0);
    endtask

    // Negative and out-of-range cores on both ops.
    task automatic test_invalid_core();
        send_item(OP_SCHED, 8'h80, 16'h0000);   // most negative
        send_item(OP_SCHED, 8'hFF, 16'hFFFF);   // minus one
        send_item(OP_SCHED, 8'(NUM_CORES), 16'h1234);
        send_item(OP_POLL,  8'h7F, 16'hFFFF);
        send_item(OP_POLL,  8'h80, 16'h0000);
    endtask

    task automatic test_empty_poll();
        send_item(OP_POLL, 8'd0, 16'h0000);
        send_item(OP_POLL, 8'(NUM_CORES - 1), 16'hFFFF);
    endtask

    // Schedule a few tasks at the field extremes and drain them, then poll
    // again to see the queue come back empty.
    task automatic test_schedule_drain();
        send_item(OP_SCHED, 8'd0, 16'hFFFF);
        send_item(OP_SCHED, 8'd0, 16'h0000);
        send_item(OP_SCHED, 8'd0, 16'h5A5A);
        send_item(OP_SCHED, 8'(NUM_CORES - 1), 16'h8001);
        send_item(OP_POLL,  8'd0, 16'h0000);
        send_item(OP_POLL,  8'(NUM_CORES - 1), 16'h0000);
        send_item(OP_POLL,  8'd0, 16'hA5A5);
        wait_queues_quiet();
    endtask

    // Fill one queue to the brim back to back, push past it, drain it whole.
    task automatic test_queue_overflow();
        logic [CORE_FW-1:0] core;
        core = 8'($urandom_range(0, NUM_CORES - 1));
        no_idle = 1'b1;
        for (int i = 0; i < QUEUE_DEPTH + 2; i++)
            send_item(OP_SCHED, core, 16'($urandom));
        no_idle = 1'b0;
        send_item(OP_POLL, core, 16'($urandom));
        send_item(OP_POLL, core, 16'($urandom));
    endtask

    // Mostly schedule runs on one core closed by a poll, with random ops on
    // any core value mixed in; some rounds run with no gaps at all.
    task automatic test_random_traffic();
        int                 round;
        int                 runlen;
        logic [CORE_FW-1:0] core;
        round = 0;
        while (items_sent < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) < 7) begin
                core   = 8'($urandom_range(0, NUM_CORES - 1));
                runlen = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                                     : $urandom_range(1, 6);
                for (int i = 0; i < runlen; i++)
                    send_item(OP_SCHED, core, 16'($urandom));
                send_item(OP_POLL, core, 16'($urandom));
            end else begin
                for (int i = 0; i < 3; i++)
                    send_item(t_op'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              16'($urandom));
            end
            round++;
            if (round % 16 == 5)
                wait_queues_quiet();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        for (int c = 0; c < NUM_CORES; c++) begin
            head_slot[c] = '0;
            queued[c]    = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_invalid_core();
        test_empty_poll();
        test_schedule_drain();
        test_queue_overflow();
        test_random_traffic();

        // let everything owed come out, then watch for stray beats
        wait_queues_quiet();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && owed_beats.size() == 0)
            $display("per_core_task_queues_top verification clean");
        else
            $display("per_core_task_queues_top verification failed");
        $finish;
    end

endmodule
